[design/distinct_window_marker_detector_top_macros.svh]
// Assertion macros used by the marker detector RTL.
`ifndef DISTINCT_WINDOW_MARKER_DETECTOR_TOP_MACROS_SVH
`define DISTINCT_WINDOW_MARKER_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define DWMD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define DWMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/dwmd_pkg.sv]
// ----------------------------------------------------------------------------
// dwmd_pkg
// Types and fixed constants of the distinct window marker detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 20;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

endpackage

[design/dwmd_ram.sv]
// ----------------------------------------------------------------------------
// dwmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dwmd_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 13,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[design/distinct_window_marker_detector_top.sv]
// ----------------------------------------------------------------------------
// Channel  | Valid     | Stall     | Payload
// ---------+-----------+-----------+---------------------------------------
// in       | in_valid  | in_stall  | data_byte
// out      | out_valid | out_stall | marker_hit, marker_position
//
// One byte is taken at a time. Its scan reads the window RAM through the
// single read port, newest entry first, one window entry per cycle, up to
// HISTORY_DEPTH entries; a newline or an empty run skips the scan. Reset
// clears the control state at once; there is no clearing pass. A stalled
// result holds the block in its output step until taken.
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_top
// Reports the first position in a line where the byte and the previous
// HISTORY_DEPTH bytes are all different. The window lives in a ring RAM; a
// run register holds the line's distinct suffix length, up to HISTORY_DEPTH + 1.
// ----------------------------------------------------------------------------
`include "distinct_window_marker_detector_top_macros.svh"

module distinct_window_marker_detector_top import dwmd_pkg::*; #(
	parameter int HISTORY_DEPTH = 13,
	parameter int COUNT_BITS    = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              marker_hit,
	output logic [POS_W-1:0]  marker_position
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int RUN_W = $clog2(HISTORY_DEPTH + 2);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic [RUN_W-1:0] RUN_DEPTH = RUN_W'(HISTORY_DEPTH);
	localparam logic [RUN_W-1:0] RUN_FULL  = RUN_W'(HISTORY_DEPTH + 1);
	localparam logic [RUN_W-1:0] RUN_ONE   = RUN_W'(1);

	state_t                  state_q;
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [RUN_W-1:0]        run_q;
	logic [RUN_W-1:0]        lim_q;
	logic [RUN_W-1:0]        dist_q;
	logic [RUN_W-1:0]        new_run_q;
	logic [COUNT_BITS-1:0]   line_pos_q;
	logic                    seen_q;
	logic                    nl_q;
	logic [BYTE_W-1:0]       byte_q;
	logic                    out_valid_q;
	logic                    hit_q;
	logic [POS_W-1:0]        pos_q;

	logic                    in_take;
	logic                    out_free;
	logic                    commit;
	logic [PTR_W-1:0]        ptr_newest;
	logic [PTR_W-1:0]        rd_addr;
	logic [BYTE_W-1:0]       rd_data;
	logic [RUN_W-1:0]        run_lim;
	logic [RUN_W-1:0]        run_grow;
	logic [COUNT_BITS-1:0]   pos_next;
	logic                    hit_next;

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	assign in_stall   = (state_q != ST_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign commit     = (state_q == ST_OUT) && out_free;
	assign ptr_newest = ptr_dec(wr_ptr_q);
	assign rd_addr    = (state_q == ST_IDLE) ? ptr_newest : rd_ptr_q;
	assign run_lim    = (run_q > RUN_DEPTH) ? RUN_DEPTH : run_q;
	assign run_grow   = (run_q >= RUN_FULL) ? RUN_FULL : run_q + RUN_ONE;
	assign pos_next   = (line_pos_q == '1) ? line_pos_q : line_pos_q + COUNT_BITS'(1);
	assign hit_next   = !nl_q && !seen_q && (new_run_q == RUN_FULL);

	// Writes land only in the output step; scan reads begin in the idle step
	// behind it, so a read never meets a write to the same entry in flight.
	dwmd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (HISTORY_DEPTH),
		.ADDR_W(PTR_W)
	) u_window (
		.clk    (clk),
		.wr_en  (commit && !nl_q),
		.wr_addr(wr_ptr_q),
		.wr_data(byte_q),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			run_q       <= '0;
			lim_q       <= '0;
			dist_q      <= '0;
			new_run_q   <= '0;
			line_pos_q  <= '0;
			seen_q      <= 1'b0;
			nl_q        <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			pos_q       <= '0;
		end else begin
			// drop the beat once taken, unless a new one loads this cycle
			if (out_valid_q && !out_stall && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						nl_q     <= (data_byte == NEWLINE_BYTE);
						lim_q    <= run_lim;
						dist_q   <= RUN_ONE;
						rd_ptr_q <= ptr_dec(ptr_newest);
						// skip the scan on a newline or an empty run
						if ((data_byte == NEWLINE_BYTE) || (run_lim == '0)) begin
							new_run_q <= RUN_ONE;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_ptr_q <= ptr_dec(rd_ptr_q);
					dist_q   <= dist_q + RUN_ONE;
					// the nearest repeat bounds the distinct run
					if (rd_data == byte_q) begin
						new_run_q <= dist_q;
						state_q   <= ST_OUT;
					end else if (dist_q == lim_q) begin
						new_run_q <= run_grow;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= hit_next;
						state_q     <= ST_IDLE;
						if (nl_q) begin
							pos_q      <= '0;
							line_pos_q <= '0;
							run_q      <= '0;
							seen_q     <= 1'b0;
						end else begin
							pos_q      <= POS_W'(pos_next);
							line_pos_q <= pos_next;
							run_q      <= new_run_q;
							seen_q     <= seen_q || hit_next;
							wr_ptr_q   <= ptr_inc(wr_ptr_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign marker_hit      = hit_q;
	assign marker_position = pos_q;

	`DWMD_ASSERT_SAME(a_run_bound, 1'b1, run_q <= RUN_FULL,
		"distinct run exceeds window plus one")
	`DWMD_ASSERT_SAME(a_scan_range, state_q == ST_SCAN,
		(dist_q != '0) && (dist_q <= lim_q), "scan distance outside window fill")
	`DWMD_ASSERT_SAME(a_hit_pos, out_valid_q && hit_q,
		seen_q && (line_pos_q >= COUNT_BITS'(HISTORY_DEPTH + 1)),
		"marker reported before a full window")
	`DWMD_ASSERT_NEXT(a_load_src, !out_valid_q && !commit, !out_valid_q,
		"result beat appeared without an output step")

endmodule

[bench/distinct_window_marker_detector_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_top_tb
// Drives byte beats into the marker detector with random sender gaps and
// receiver stalls, predicts every result beat, and checks the hit flag and
// the line position in order. Covers short lines, broken distinct runs,
// newline clears and a closing stretch with no gaps or stalls.
// ----------------------------------------------------------------------------
import dwmd_pkg::*;

class marker_scoreboard;
	localparam int WINDOW_DEPTH = 13;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] position;
	} marker_beat_t;

	logic [BYTE_W-1:0] window [WINDOW_DEPTH];
	int unsigned       fill;
	logic [POS_W-1:0]  position;
	bit                seen;
	marker_beat_t      expected_q[$];
	int                errors;

	function new();
		fill = 0;
		position = '0;
		seen = 0;
		errors = 0;
	endfunction

	function bit window_distinct(logic [BYTE_W-1:0] b);
		bit [255:0] present;
		present = '0;
		present[b] = 1'b1;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (present[window[i]])
				return 0;
			present[window[i]] = 1'b1;
		end
		return 1;
	endfunction

	// Predict the result beat caused by one accepted byte.
	function void note_byte(logic [BYTE_W-1:0] b);
		marker_beat_t exp_beat;
		exp_beat = '0;
		if (b == NEWLINE_BYTE) begin
			fill = 0;
			position = '0;
			seen = 0;
		end else begin
			if (position != {POS_W{1'b1}})
				position = position + POS_W'(1);
			if (!seen && fill >= WINDOW_DEPTH && window_distinct(b)) begin
				exp_beat.hit = 1'b1;
				seen = 1;
			end
			for (int i = WINDOW_DEPTH - 1; i > 0; i--)
				window[i] = window[i - 1];
			window[0] = b;
			if (fill < WINDOW_DEPTH)
				fill++;
			exp_beat.position = position;
		end
		expected_q.push_back(exp_beat);
	endfunction

	function void check_result(logic hit, logic [POS_W-1:0] pos);
		marker_beat_t exp_beat;
		if (expected_q.size() == 0) begin
			$error("result beat with nothing expected: marker_hit=%0d marker_position=%0d",
				hit, pos);
			errors++;
			return;
		end
		exp_beat = expected_q.pop_front();
		if (hit !== exp_beat.hit) begin
			$error("marker_hit expected %0d actual %0d", exp_beat.hit, hit);
			errors++;
		end
		if (pos !== exp_beat.position) begin
			$error("marker_position expected %0d actual %0d", exp_beat.position, pos);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void final_check();
		if (expected_q.size() != 0) begin
			$error("%0d result beats never arrived", expected_q.size());
			errors++;
		end
	endfunction
endclass

module distinct_window_marker_detector_top_tb;

	localparam int WINDOW_DEPTH  = 13;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int CALM_ITEMS    = 200;
	// Slowest run: about 2500 beats with full window scans, plus full sender
	// gaps and receiver stalls on every beat, taken several times over.
	localparam longint CYCLE_LIMIT = 1_000_000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              out_valid;
	logic              out_stall;
	logic              marker_hit;
	logic [POS_W-1:0]  marker_position;

	marker_scoreboard sb;
	bit               idle_on;
	int               items_sent;
	int               tx_calm_left;
	int               rx_stall_left;
	int               rx_calm_left;
	longint           cycle_count;

	distinct_window_marker_detector_top #(
		.HISTORY_DEPTH(WINDOW_DEPTH),
		.COUNT_BITS   (POS_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.marker_hit     (marker_hit),
		.marker_position(marker_position)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stall bursts between calm stretches.
	always @(negedge clk) begin
		if (!idle_on) begin
			out_stall = 1'b0;
			rx_stall_left = 0;
		end else if (rx_stall_left > 0) begin
			out_stall = 1'b1;
			rx_stall_left--;
		end else if (rx_calm_left > 0) begin
			out_stall = 1'b0;
			rx_calm_left--;
		end else begin
			out_stall = 1'b1;
			rx_stall_left = $urandom_range(1, 17) - 1;
			rx_calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(marker_hit, marker_position);
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap_len;
		@(negedge clk);
		in_valid = 1'b1;
		data_byte = b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		items_sent++;
		if (idle_on) begin
			if (tx_calm_left > 0) begin
				tx_calm_left--;
			end else begin
				gap_len = $urandom_range(1, 17);
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap_len - 1) @(negedge clk);
				tx_calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
					: $urandom_range(0, 6);
			end
		end
	endtask

	// Hold the sender off until every expected beat has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Distinct run from an odd stride, optionally broken by a repeat.
	task automatic send_stride_run(input int len, input bit broken);
		logic [BYTE_W-1:0] start;
		logic [BYTE_W-1:0] stride;
		int                brk;
		start = BYTE_W'($urandom_range(0, 255));
		stride = BYTE_W'($urandom_range(0, 127) * 2 + 1);
		brk = broken ? $urandom_range(1, len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == brk)
				send_byte(BYTE_W'(start + (i - $urandom_range(1,
					(i < WINDOW_DEPTH) ? i : WINDOW_DEPTH)) * stride));
			else
				send_byte(BYTE_W'(start + i * stride));
		end
	endtask

	task automatic send_random_line();
		int                mode;
		int                len;
		int                k;
		logic [BYTE_W-1:0] base;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2, 3: begin
				send_stride_run($urandom_range(14, 40), $urandom_range(0, 2) == 0);
			end
			4, 5: begin
				k = $urandom_range(14, 20);
				base = BYTE_W'($urandom_range(0, 255));
				len = $urandom_range(20, 120);
				repeat (len) send_byte(BYTE_W'(base + $urandom_range(0, k - 1)));
			end
			6: begin
				// too few symbols for a distinct window
				k = $urandom_range(1, WINDOW_DEPTH);
				base = BYTE_W'($urandom_range(0, 255));
				len = $urandom_range(1, 30);
				repeat (len) send_byte(BYTE_W'(base + $urandom_range(0, k - 1)));
			end
			7, 8: begin
				len = $urandom_range(1, 50);
				repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
			default: begin
				len = $urandom_range(200, 400);
				repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		endcase
		// mostly end the line; otherwise let it run into the next one
		if ($urandom_range(0, 7) != 0)
			send_byte(NEWLINE_BYTE);
	endtask

	initial begin
		bit drained_mid;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		out_stall = 1'b0;
		idle_on = 1'b1;
		items_sent = 0;
		tx_calm_left = 0;
		rx_stall_left = 0;
		rx_calm_left = 0;
		cycle_count = 0;
		drained_mid = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Newline straight after reset, then 13 distinct bytes (no hit while
		// the window fills) and a bang that completes the window.
		send_byte(NEWLINE_BYTE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h0F);
		send_byte(8'hF0);
		send_byte(8'h33);
		send_byte(8'hCC);
		send_byte(8'h20);
		send_byte(8'h21);
		// marker already seen: no second hit
		send_byte(8'h5A);
		send_byte(NEWLINE_BYTE);
		send_byte(8'h21);
		send_byte(8'h21);
		send_byte(8'h21);
		send_byte(NEWLINE_BYTE);
		drain_results();

		while (items_sent < RANDOM_ITEMS - CALM_ITEMS) begin
			send_random_line();
			if (!drained_mid && items_sent > (RANDOM_ITEMS - CALM_ITEMS) / 2) begin
				drain_results();
				drained_mid = 1;
			end
		end
		send_byte(NEWLINE_BYTE);
		drain_results();

		// Closing stretch: beats back to back, results taken at once.
		idle_on = 1'b0;
		while (items_sent < RANDOM_ITEMS)
			send_random_line();
		send_byte(NEWLINE_BYTE);
		send_byte(8'h42);

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (WINDOW_DEPTH + 8) @(posedge clk);
		sb.final_check();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
